@@ rtl/tfwv_pkg.sv @@
// Shared types, constants and fixed-point helpers of the three-field wave stepper.
`default_nettype none

package tfwv_pkg;

    localparam int GRID_POINTS = 4096;
    localparam int ADDR_W      = $clog2(GRID_POINTS);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int DIV_STEPS   = 52;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [PTR_W-1:0]  PTR_END  = PTR_W'(GRID_POINTS);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(GRID_POINTS - 1);
    localparam logic [15:0]       DAMP_ONE = 16'd32768;

    typedef logic signed [31:0] word_t;
    typedef logic [2:0][31:0]   tri_t;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;
    localparam word_t ONE_Q    = 32'sd1048576;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    typedef enum logic [2:0] {
        CFG_TIME_STEP       = 3'd0,
        CFG_INV_DX_SQ       = 3'd1,
        CFG_MASS_SQ_UP      = 3'd2,
        CFG_MASS_SQ_DOWN    = 3'd3,
        CFG_MASS_MODE       = 3'd4,
        CFG_COUPLING_LAMBDA = 3'd5,
        CFG_TRIPLE_MU       = 3'd6,
        CFG_TRIPLE_KAPPA    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SH_Q20,
        SH_HALF,
        SH_DAMP
    } sh_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_TAKE,
        ST_K1_MA,
        ST_K1_AV,
        ST_K1_MV,
        ST_K1_AF,
        ST_DISPATCH,
        ST_C_M12,
        ST_C_A12,
        ST_C_MP,
        ST_C_AP,
        ST_C_MPP,
        ST_C_APP,
        ST_C_MK,
        ST_C_AK,
        ST_C_MD,
        ST_C_AD,
        ST_C_MM,
        ST_C_AM,
        ST_A_ML,
        ST_A_AL,
        ST_A_MM,
        ST_A_AM,
        ST_A_MDP,
        ST_A_ADP,
        ST_A_MN,
        ST_A_AN,
        ST_A_DIV,
        ST_A_MC,
        ST_A_AC,
        ST_K2_M,
        ST_K2_A,
        ST_DP_MV,
        ST_DP_AV,
        ST_DP_MF,
        ST_DP_AF,
        ST_WRITE,
        ST_STEPOUT
    } state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        point_index;
        logic signed [31:0] field_one_in;
        logic signed [31:0] field_two_in;
        logic signed [31:0] field_three_in;
        logic signed [31:0] rate_one_in;
        logic signed [31:0] rate_two_in;
        logic signed [31:0] rate_three_in;
        logic [15:0]        damp_factor;
    } req_item_t;

    typedef struct packed {
        logic [11:0]        point_out;
        logic signed [31:0] field_one_out;
        logic signed [31:0] field_two_out;
        logic signed [31:0] field_three_out;
        logic signed [31:0] rate_one_out;
        logic signed [31:0] rate_two_out;
        logic signed [31:0] rate_three_out;
        logic               step_done;
    } rsp_item_t;

    // One memory word holds everything stored for one grid point.
    typedef struct packed {
        tri_t        f;
        tri_t        v;
        tri_t        a;
        logic [15:0] d;
    } pt_word_t;

    localparam int WORD_W = $bits(pt_word_t);

    function automatic word_t sat32(input logic signed [64:0] v);
        word_t r;
        if (v > 65'sd2147483647) begin
            r = WORD_MAX;
        end
        else if (v < -65'sd2147483648) begin
            r = WORD_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [64:0] ext65(input word_t a);
        return {{33{a[31]}}, a};
    endfunction

    function automatic word_t sadd(input word_t a, input word_t b);
        return sat32(ext65(a) + ext65(b));
    endfunction

    function automatic word_t sneg(input word_t a);
        return sat32(65'sd0 - ext65(a));
    endfunction

    // Round half up, floor shift, saturate.
    function automatic word_t mul_round(input logic signed [63:0] p, input sh_t s);
        logic signed [64:0] x;
        logic signed [64:0] y;
        x = {p[63], p};
        case (s)
            SH_HALF: y = (x + 65'sd1048576) >>> 21;
            SH_DAMP: y = (x + 65'sd16384) >>> 15;
            default: y = (x + 65'sd524288) >>> 20;
        endcase
        return sat32(y);
    endfunction

    // Rotate the three field slots so that the next field comes to slot 0.
    function automatic tri_t rot3(input tri_t v, input word_t n0);
        tri_t r;
        r[0] = v[1];
        r[1] = v[2];
        r[2] = n0;
        return r;
    endfunction

    function automatic logic is_inner(input logic [PTR_W-1:0] x);
        return (x != '0) && (x < PTR_LAST);
    endfunction

endpackage

`default_nettype wire

@@ rtl/tfwv_if.sv @@
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface tfwv_req_if;
    logic                 valid;
    logic                 ready;
    tfwv_pkg::req_item_t  item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface tfwv_rsp_if;
    logic                 valid;
    logic                 ready;
    tfwv_pkg::rsp_item_t  item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ rtl/three_field_wave_verlet_step_top.sv @@
// Load/read: a load is written in its accept cycle; a read result passes the memory's
// read register and then the result register, which waits for any earlier beat to go.
// Step: each grid point makes one pass through the point memory and a shared 32x32 multiplier;
// most time goes to the radix-2 divider, three divides per inner point. With stale
// accelerations a first pass that only sets them comes first. One item is in work at a time.
// Reset sets the registers to their defaults and marks accelerations stale; memory is not cleared.
`default_nettype none

module three_field_wave_verlet_step_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tfwv_req_if.sink           req,
    tfwv_rsp_if.source         rsp,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int AW = tfwv_pkg::ADDR_W;
    localparam int PW = tfwv_pkg::PTR_W;

    tfwv_pkg::state_t state_reg, state_next;

    // Configuration
    tfwv_pkg::word_t time_step_reg, inv_dx_sq_reg, mass_sq_up_reg, mass_sq_down_reg;
    tfwv_pkg::word_t coupling_lambda_reg, triple_mu_reg, triple_kappa_reg;
    logic            mass_mode_reg;

    // Control
    logic [PW-1:0]   ptr_reg;
    logic [1:0]      fcnt_reg;
    logic            main_reg;
    logic            accel_valid_reg;
    logic            rsp_valid_reg;
    logic            div_busy_reg;
    logic [tfwv_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    // Point window and working registers
    tfwv_pkg::tri_t  prev_f_reg, cur_f_reg, cur_v_reg, cur_a_reg;
    tfwv_pkg::tri_t  nxt_f_reg, nxt_v_reg, nxt_a_reg, wb_f_reg;
    logic [15:0]     cur_d_reg, nxt_d_reg;
    tfwv_pkg::word_t t_reg, p_reg, den_reg, mp_reg, acc_reg, tv_reg;
    logic signed [63:0] prod_reg;
    tfwv_pkg::sh_t   sh_reg;
    logic [11:0]     rd_idx_reg;
    logic            rd_ok_reg;
    tfwv_pkg::rsp_item_t rsp_reg;

    // Divider
    logic [31:0]     div_rem_reg, div_ad_reg;
    logic [51:0]     div_quo_reg;
    logic            div_neg_reg, div_zero_reg;
    tfwv_pkg::word_t div_zres_reg;

    // Combinational
    tfwv_pkg::word_t mul_a, mul_b, mul_res, m2_sel, div_q, acc_fin;
    tfwv_pkg::sh_t   mul_sh;
    logic            ram_we, ram_re, rsp_load, div_start, accepted, in_range, last_f;
    logic [AW-1:0]   ram_waddr, ram_raddr, cur_addr;
    logic [PW-1:0]   cur_idx;
    tfwv_pkg::pt_word_t ram_wdata, ram_rdata, load_word, wb_word;
    logic signed [33:0] d2;
    logic [32:0]     rem_sh;
    logic            rem_ge;

    tfwv_ram #(
        .WIDTH (tfwv_pkg::WORD_W),
        .DEPTH (tfwv_pkg::GRID_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == tfwv_pkg::ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.item  = rsp_reg;

    assign accepted = req.valid && req.ready;
    assign in_range = ({1'b0, req.item.point_index} < PW'(tfwv_pkg::GRID_POINTS));
    assign last_f   = (fcnt_reg == 2'd2);
    assign cur_idx  = ptr_reg - PW'(1);
    assign cur_addr = cur_idx[AW-1:0];
    assign mul_res  = tfwv_pkg::mul_round(prod_reg, sh_reg);
    assign rsp_load = ((state_reg == tfwv_pkg::ST_READ) || (state_reg == tfwv_pkg::ST_STEPOUT))
                      && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        load_word.f[0] = req.item.field_one_in;
        load_word.f[1] = req.item.field_two_in;
        load_word.f[2] = req.item.field_three_in;
        load_word.v[0] = req.item.rate_one_in;
        load_word.v[1] = req.item.rate_two_in;
        load_word.v[2] = req.item.rate_three_in;
        load_word.a    = '0;
        load_word.d    = (req.item.damp_factor > tfwv_pkg::DAMP_ONE) ? tfwv_pkg::DAMP_ONE
                                                                     : req.item.damp_factor;
        wb_word.f = main_reg ? wb_f_reg : cur_f_reg;
        wb_word.v = cur_v_reg;
        wb_word.a = cur_a_reg;
        wb_word.d = cur_d_reg;
    end

    always_comb
    begin
        case (fcnt_reg)
            2'd0:    m2_sel = mass_sq_up_reg;
            2'd1:    m2_sel = mass_mode_reg ? mass_sq_up_reg : mass_sq_down_reg;
            default: m2_sel = mass_sq_down_reg;
        endcase
    end

    // Second difference of the field in slot 0, exact before saturation.
    assign d2 = {{2{nxt_f_reg[0][31]}}, nxt_f_reg[0]}
              - {{1{cur_f_reg[0][31]}}, cur_f_reg[0], 1'b0}
              + {{2{prev_f_reg[0][31]}}, prev_f_reg[0]};

    assign acc_fin = tfwv_pkg::sadd(acc_reg, tfwv_pkg::sneg(mul_res));

    // Divider quotient with sign and saturation applied, or the saturated result for a zero divisor.
    always_comb
    begin
        if (div_zero_reg)
        begin
            div_q = div_zres_reg;
        end
        else if (div_neg_reg)
        begin
            div_q = (div_quo_reg > 52'h8000_0000) ? tfwv_pkg::WORD_MIN
                                                  : tfwv_pkg::word_t'(-div_quo_reg[31:0]);
        end
        else
        begin
            div_q = (div_quo_reg > 52'h7FFF_FFFF) ? tfwv_pkg::WORD_MAX
                                                  : tfwv_pkg::word_t'(div_quo_reg[31:0]);
        end
    end

    assign rem_sh = {div_rem_reg, div_quo_reg[51]};
    assign rem_ge = (rem_sh >= {1'b0, div_ad_reg});

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        mul_sh     = tfwv_pkg::SH_Q20;
        ram_we     = 1'b0;
        ram_waddr  = cur_addr;
        ram_wdata  = wb_word;
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg[AW-1:0];
        div_start  = 1'b0;
        case (state_reg)
            tfwv_pkg::ST_IDLE:
            begin
                if (accepted)
                begin
                    case (req.item.kind)
                        tfwv_pkg::KIND_LOAD:
                        begin
                            ram_we    = in_range;
                            ram_waddr = req.item.point_index[AW-1:0];
                            ram_wdata = load_word;
                        end
                        tfwv_pkg::KIND_STEP:
                        begin
                            state_next = tfwv_pkg::ST_FETCH;
                        end
                        tfwv_pkg::KIND_READ:
                        begin
                            ram_re     = in_range;
                            ram_raddr  = req.item.point_index[AW-1:0];
                            state_next = tfwv_pkg::ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tfwv_pkg::ST_READ:
            begin
                if (rsp_load)
                begin
                    state_next = tfwv_pkg::ST_IDLE;
                end
            end
            tfwv_pkg::ST_FETCH:
            begin
                ram_re     = (ptr_reg != tfwv_pkg::PTR_END);
                state_next = tfwv_pkg::ST_TAKE;
            end
            tfwv_pkg::ST_TAKE:
            begin
                if ((ptr_reg != tfwv_pkg::PTR_END) && main_reg && tfwv_pkg::is_inner(ptr_reg))
                begin
                    state_next = tfwv_pkg::ST_K1_MA;
                end
                else
                begin
                    state_next = tfwv_pkg::ST_DISPATCH;
                end
            end
            tfwv_pkg::ST_K1_MA:
            begin
                mul_a      = time_step_reg;
                mul_b      = nxt_a_reg[0];
                mul_sh     = tfwv_pkg::SH_HALF;
                state_next = tfwv_pkg::ST_K1_AV;
            end
            tfwv_pkg::ST_K1_AV:
            begin
                state_next = tfwv_pkg::ST_K1_MV;
            end
            tfwv_pkg::ST_K1_MV:
            begin
                mul_a      = time_step_reg;
                mul_b      = nxt_v_reg[0];
                state_next = tfwv_pkg::ST_K1_AF;
            end
            tfwv_pkg::ST_K1_AF:
            begin
                state_next = last_f ? tfwv_pkg::ST_DISPATCH : tfwv_pkg::ST_K1_MA;
            end
            tfwv_pkg::ST_DISPATCH:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = tfwv_pkg::ST_FETCH;
                end
                else if (tfwv_pkg::is_inner(cur_idx))
                begin
                    state_next = tfwv_pkg::ST_C_M12;
                end
                else
                begin
                    state_next = main_reg ? tfwv_pkg::ST_DP_MV : tfwv_pkg::ST_WRITE;
                end
            end
            tfwv_pkg::ST_C_M12:
            begin
                mul_a      = cur_f_reg[0];
                mul_b      = cur_f_reg[1];
                state_next = tfwv_pkg::ST_C_A12;
            end
            tfwv_pkg::ST_C_A12: state_next = tfwv_pkg::ST_C_MP;
            tfwv_pkg::ST_C_MP:
            begin
                mul_a      = t_reg;
                mul_b      = cur_f_reg[2];
                state_next = tfwv_pkg::ST_C_AP;
            end
            tfwv_pkg::ST_C_AP: state_next = tfwv_pkg::ST_C_MPP;
            tfwv_pkg::ST_C_MPP:
            begin
                mul_a      = p_reg;
                mul_b      = p_reg;
                state_next = tfwv_pkg::ST_C_APP;
            end
            tfwv_pkg::ST_C_APP: state_next = tfwv_pkg::ST_C_MK;
            tfwv_pkg::ST_C_MK:
            begin
                mul_a      = triple_kappa_reg;
                mul_b      = t_reg;
                state_next = tfwv_pkg::ST_C_AK;
            end
            tfwv_pkg::ST_C_AK: state_next = tfwv_pkg::ST_C_MD;
            tfwv_pkg::ST_C_MD:
            begin
                mul_a      = t_reg;
                mul_b      = t_reg;
                state_next = tfwv_pkg::ST_C_AD;
            end
            tfwv_pkg::ST_C_AD: state_next = tfwv_pkg::ST_C_MM;
            tfwv_pkg::ST_C_MM:
            begin
                mul_a      = tfwv_pkg::sneg(triple_mu_reg);
                mul_b      = p_reg;
                state_next = tfwv_pkg::ST_C_AM;
            end
            tfwv_pkg::ST_C_AM: state_next = tfwv_pkg::ST_A_ML;
            tfwv_pkg::ST_A_ML:
            begin
                mul_a      = tfwv_pkg::sat32({{31{d2[33]}}, d2});
                mul_b      = inv_dx_sq_reg;
                state_next = tfwv_pkg::ST_A_AL;
            end
            tfwv_pkg::ST_A_AL: state_next = tfwv_pkg::ST_A_MM;
            tfwv_pkg::ST_A_MM:
            begin
                mul_a      = m2_sel;
                mul_b      = cur_f_reg[0];
                state_next = tfwv_pkg::ST_A_AM;
            end
            tfwv_pkg::ST_A_AM: state_next = tfwv_pkg::ST_A_MDP;
            tfwv_pkg::ST_A_MDP:
            begin
                mul_a      = cur_f_reg[1];
                mul_b      = cur_f_reg[2];
                state_next = tfwv_pkg::ST_A_ADP;
            end
            tfwv_pkg::ST_A_ADP: state_next = tfwv_pkg::ST_A_MN;
            tfwv_pkg::ST_A_MN:
            begin
                mul_a      = mp_reg;
                mul_b      = t_reg;
                state_next = tfwv_pkg::ST_A_AN;
            end
            tfwv_pkg::ST_A_AN:
            begin
                div_start  = 1'b1;
                state_next = tfwv_pkg::ST_A_DIV;
            end
            tfwv_pkg::ST_A_DIV:
            begin
                if (!div_busy_reg)
                begin
                    state_next = tfwv_pkg::ST_A_MC;
                end
            end
            tfwv_pkg::ST_A_MC:
            begin
                mul_a      = coupling_lambda_reg;
                mul_b      = tfwv_pkg::sadd(cur_f_reg[1], cur_f_reg[2]);
                state_next = tfwv_pkg::ST_A_AC;
            end
            tfwv_pkg::ST_A_AC:
            begin
                if (!last_f)
                begin
                    state_next = tfwv_pkg::ST_A_ML;
                end
                else
                begin
                    state_next = main_reg ? tfwv_pkg::ST_K2_M : tfwv_pkg::ST_WRITE;
                end
            end
            tfwv_pkg::ST_K2_M:
            begin
                mul_a      = time_step_reg;
                mul_b      = cur_a_reg[0];
                mul_sh     = tfwv_pkg::SH_HALF;
                state_next = tfwv_pkg::ST_K2_A;
            end
            tfwv_pkg::ST_K2_A:
            begin
                state_next = last_f ? tfwv_pkg::ST_DP_MV : tfwv_pkg::ST_K2_M;
            end
            tfwv_pkg::ST_DP_MV:
            begin
                mul_a      = cur_v_reg[0];
                mul_b      = tfwv_pkg::word_t'({16'b0, cur_d_reg});
                mul_sh     = tfwv_pkg::SH_DAMP;
                state_next = tfwv_pkg::ST_DP_AV;
            end
            tfwv_pkg::ST_DP_AV: state_next = tfwv_pkg::ST_DP_MF;
            tfwv_pkg::ST_DP_MF:
            begin
                mul_a      = cur_f_reg[0];
                mul_b      = tfwv_pkg::word_t'({16'b0, cur_d_reg});
                mul_sh     = tfwv_pkg::SH_DAMP;
                state_next = tfwv_pkg::ST_DP_AF;
            end
            tfwv_pkg::ST_DP_AF:
            begin
                state_next = last_f ? tfwv_pkg::ST_WRITE : tfwv_pkg::ST_DP_MV;
            end
            tfwv_pkg::ST_WRITE:
            begin
                ram_we = 1'b1;
                if (ptr_reg != tfwv_pkg::PTR_END)
                begin
                    state_next = tfwv_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = main_reg ? tfwv_pkg::ST_STEPOUT : tfwv_pkg::ST_FETCH;
                end
            end
            tfwv_pkg::ST_STEPOUT:
            begin
                if (rsp_load)
                begin
                    state_next = tfwv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tfwv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfwv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg       <= 32'sd41943;
            inv_dx_sq_reg       <= 32'sd419430400;
            mass_sq_up_reg      <= 32'sd1048576;
            mass_sq_down_reg    <= 32'sd1048576;
            mass_mode_reg       <= 1'b0;
            coupling_lambda_reg <= 32'sd891289;
            triple_mu_reg       <= -32'sd20971520;
            triple_kappa_reg    <= 32'sd20971520;
        end
        else if (cfg_we)
        begin
            case (tfwv_pkg::cfg_idx_t'(cfg_index))
                tfwv_pkg::CFG_TIME_STEP:       time_step_reg       <= cfg_data;
                tfwv_pkg::CFG_INV_DX_SQ:       inv_dx_sq_reg       <= cfg_data;
                tfwv_pkg::CFG_MASS_SQ_UP:      mass_sq_up_reg      <= cfg_data;
                tfwv_pkg::CFG_MASS_SQ_DOWN:    mass_sq_down_reg    <= cfg_data;
                tfwv_pkg::CFG_MASS_MODE:       mass_mode_reg       <= cfg_data[0];
                tfwv_pkg::CFG_COUPLING_LAMBDA: coupling_lambda_reg <= cfg_data;
                tfwv_pkg::CFG_TRIPLE_MU:       triple_mu_reg       <= cfg_data;
                tfwv_pkg::CFG_TRIPLE_KAPPA:    triple_kappa_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Sweep pointer, field counter, pass flags, result valid and divider control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            fcnt_reg        <= '0;
            main_reg        <= 1'b0;
            accel_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            div_busy_reg    <= 1'b0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (div_start)
            begin
                div_busy_reg <= (den_reg != '0);
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == tfwv_pkg::DIV_CNT_W'(tfwv_pkg::DIV_STEPS - 1))
                begin
                    div_busy_reg <= 1'b0;
                end
            end

            case (state_reg)
                tfwv_pkg::ST_IDLE:
                begin
                    if (accepted && (req.item.kind == tfwv_pkg::KIND_LOAD) && in_range)
                    begin
                        accel_valid_reg <= 1'b0;
                    end
                    if (accepted && (req.item.kind == tfwv_pkg::KIND_STEP))
                    begin
                        ptr_reg  <= '0;
                        main_reg <= accel_valid_reg;
                    end
                end
                tfwv_pkg::ST_TAKE:
                begin
                    fcnt_reg <= '0;
                end
                tfwv_pkg::ST_K1_AF, tfwv_pkg::ST_A_AC, tfwv_pkg::ST_K2_A, tfwv_pkg::ST_DP_AF:
                begin
                    fcnt_reg <= last_f ? 2'd0 : fcnt_reg + 2'd1;
                end
                tfwv_pkg::ST_DISPATCH:
                begin
                    if (ptr_reg == '0)
                    begin
                        ptr_reg <= PW'(1);
                    end
                end
                tfwv_pkg::ST_WRITE:
                begin
                    if (ptr_reg != tfwv_pkg::PTR_END)
                    begin
                        ptr_reg <= ptr_reg + PW'(1);
                    end
                    else if (main_reg)
                    begin
                        accel_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        main_reg <= 1'b1;
                        ptr_reg  <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        sh_reg   <= mul_sh;

        if (div_start)
        begin
            div_rem_reg  <= '0;
            div_quo_reg  <= {(mul_res[31] ? 32'(-mul_res) : 32'(mul_res)), 20'b0};
            div_ad_reg   <= den_reg[31] ? 32'(-den_reg) : 32'(den_reg);
            div_neg_reg  <= mul_res[31] ^ den_reg[31];
            div_zero_reg <= (den_reg == '0);
            if (mul_res == '0)
            begin
                div_zres_reg <= '0;
            end
            else
            begin
                div_zres_reg <= mul_res[31] ? tfwv_pkg::WORD_MIN : tfwv_pkg::WORD_MAX;
            end
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= rem_ge ? 32'(rem_sh - {1'b0, div_ad_reg}) : rem_sh[31:0];
            div_quo_reg <= {div_quo_reg[50:0], rem_ge};
        end

        case (state_reg)
            tfwv_pkg::ST_IDLE:
            begin
                if (accepted)
                begin
                    rd_idx_reg <= req.item.point_index;
                    rd_ok_reg  <= in_range;
                end
            end
            tfwv_pkg::ST_READ:
            begin
                // The result register only moves once any earlier beat has gone.
                if (rsp_load)
                begin
                    rsp_reg.point_out       <= rd_idx_reg;
                    rsp_reg.field_one_out   <= rd_ok_reg ? ram_rdata.f[0] : '0;
                    rsp_reg.field_two_out   <= rd_ok_reg ? ram_rdata.f[1] : '0;
                    rsp_reg.field_three_out <= rd_ok_reg ? ram_rdata.f[2] : '0;
                    rsp_reg.rate_one_out    <= rd_ok_reg ? ram_rdata.v[0] : '0;
                    rsp_reg.rate_two_out    <= rd_ok_reg ? ram_rdata.v[1] : '0;
                    rsp_reg.rate_three_out  <= rd_ok_reg ? ram_rdata.v[2] : '0;
                    rsp_reg.step_done       <= 1'b0;
                end
            end
            tfwv_pkg::ST_STEPOUT:
            begin
                if (rsp_load)
                begin
                    rsp_reg.point_out       <= '0;
                    rsp_reg.field_one_out   <= '0;
                    rsp_reg.field_two_out   <= '0;
                    rsp_reg.field_three_out <= '0;
                    rsp_reg.rate_one_out    <= '0;
                    rsp_reg.rate_two_out    <= '0;
                    rsp_reg.rate_three_out  <= '0;
                    rsp_reg.step_done       <= 1'b1;
                end
            end
            tfwv_pkg::ST_TAKE:
            begin
                prev_f_reg <= cur_f_reg;
                cur_f_reg  <= nxt_f_reg;
                cur_v_reg  <= nxt_v_reg;
                cur_a_reg  <= nxt_a_reg;
                cur_d_reg  <= nxt_d_reg;
                if (ptr_reg != tfwv_pkg::PTR_END)
                begin
                    nxt_f_reg <= ram_rdata.f;
                    nxt_v_reg <= ram_rdata.v;
                    nxt_a_reg <= ram_rdata.a;
                    nxt_d_reg <= ram_rdata.d;
                end
            end
            tfwv_pkg::ST_K1_AV:
            begin
                nxt_v_reg[0] <= tfwv_pkg::sadd(nxt_v_reg[0], mul_res);
            end
            tfwv_pkg::ST_K1_AF:
            begin
                nxt_f_reg <= tfwv_pkg::rot3(nxt_f_reg, tfwv_pkg::sadd(nxt_f_reg[0], mul_res));
                nxt_v_reg <= tfwv_pkg::rot3(nxt_v_reg, nxt_v_reg[0]);
                nxt_a_reg <= tfwv_pkg::rot3(nxt_a_reg, nxt_a_reg[0]);
            end
            tfwv_pkg::ST_DISPATCH:
            begin
                // The grid ends carry no acceleration.
                if ((ptr_reg != '0) && !tfwv_pkg::is_inner(cur_idx))
                begin
                    cur_a_reg <= '0;
                end
            end
            tfwv_pkg::ST_C_A12, tfwv_pkg::ST_C_APP, tfwv_pkg::ST_A_ADP:
            begin
                t_reg <= mul_res;
            end
            tfwv_pkg::ST_C_AP:  p_reg   <= mul_res;
            tfwv_pkg::ST_C_AK:  t_reg   <= tfwv_pkg::sadd(tfwv_pkg::ONE_Q, mul_res);
            tfwv_pkg::ST_C_AD:  den_reg <= mul_res;
            tfwv_pkg::ST_C_AM:  mp_reg  <= mul_res;
            tfwv_pkg::ST_A_AL:  acc_reg <= mul_res;
            tfwv_pkg::ST_A_AM:  acc_reg <= acc_fin;
            tfwv_pkg::ST_A_DIV:
            begin
                if (!div_busy_reg)
                begin
                    acc_reg <= tfwv_pkg::sadd(acc_reg, div_q);
                end
            end
            tfwv_pkg::ST_A_AC:
            begin
                cur_a_reg  <= tfwv_pkg::rot3(cur_a_reg, acc_fin);
                prev_f_reg <= tfwv_pkg::rot3(prev_f_reg, prev_f_reg[0]);
                cur_f_reg  <= tfwv_pkg::rot3(cur_f_reg, cur_f_reg[0]);
                nxt_f_reg  <= tfwv_pkg::rot3(nxt_f_reg, nxt_f_reg[0]);
                cur_v_reg  <= tfwv_pkg::rot3(cur_v_reg, cur_v_reg[0]);
            end
            tfwv_pkg::ST_K2_A:
            begin
                cur_v_reg <= tfwv_pkg::rot3(cur_v_reg, tfwv_pkg::sadd(cur_v_reg[0], mul_res));
                cur_a_reg <= tfwv_pkg::rot3(cur_a_reg, cur_a_reg[0]);
            end
            tfwv_pkg::ST_DP_AV: tv_reg <= mul_res;
            tfwv_pkg::ST_DP_AF:
            begin
                // The damped field goes to the write-back copy; the window keeps the
                // undamped value for the next point's stencil.
                wb_f_reg  <= tfwv_pkg::rot3(wb_f_reg, mul_res);
                cur_v_reg <= tfwv_pkg::rot3(cur_v_reg, tv_reg);
                cur_f_reg <= tfwv_pkg::rot3(cur_f_reg, cur_f_reg[0]);
                cur_a_reg <= tfwv_pkg::rot3(cur_a_reg, cur_a_reg[0]);
            end
            default:
            begin
            end
        endcase
    end

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("memory read and write hit the same point");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> (state_reg == tfwv_pkg::ST_A_DIV))
        else $error("divider busy outside its wait state");

    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg != 2'd3)
        else $error("field counter out of range");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= tfwv_pkg::PTR_END)
        else $error("sweep pointer beyond the grid");

    a_step_leaves_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tfwv_pkg::ST_STEPOUT) |-> accel_valid_reg)
        else $error("step acknowledged with stale accelerations");

endmodule

`default_nettype wire

@@ rtl/tfwv_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tfwv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
